/* src/smt_pkg.sv */
// Shared types and codes for the sliding mode tracker.
// It depends on nothing. The front, back and top level import it.
package smt_pkg;

  // Operation codes carried in each input word.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Error codes reported with every result word.
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_ABSENT = 2'd2;

  // Field widths fixed by the interface.
  localparam int KEY_W = 64;
  localparam int ROW_W = 32;
  localparam int CNT_W = 32;
  localparam int DN_W  = 9;

  // Number of slots in the command queue between front and back.
  localparam int QDEPTH = 2;

  // One accepted command.
  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row;
  } cmd_t;

  // One row of the frequency table.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] frow;
  } entry_t;

endpackage

/* src/sliding_mode_tracker.sv */
// An add or remove searches the used rows until its key is found or every used row is seen.
// A query with a stale mode rescans all used rows.
// Clear and a query with a fresh mode or an empty table go straight to the result; one word is worked at a time.
// The table memory is read once per cycle, which sets the search and rescan length.
// Reset (rst_n low, synchronous) empties the table and the queue; no clearing pass.
module sliding_mode_tracker import smt_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [KEY_W-1:0] in_key_value,
  input  logic [ROW_W-1:0] in_row_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_mode_key,
  output logic [CNT_W-1:0] out_mode_count,
  output logic             out_mode_valid,
  output logic [DN_W-1:0]  out_distinct_nonzero,
  output logic [1:0]       out_error_code
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Front: accepts each word into the command queue.
  smt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key_value (in_key_value),
    .in_row_index (in_row_index),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: runs each command against the table and drives the result word.
  smt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mode_key         (out_mode_key),
    .out_mode_count       (out_mode_count),
    .out_mode_valid       (out_mode_valid),
    .out_distinct_nonzero (out_distinct_nonzero),
    .out_error_code       (out_error_code)
  );

endmodule

/* src/smt_front.sv */
// Front part of the sliding mode tracker: accepts input words and queues them.
// It depends on smt_pkg and feeds smt_back through a small queue.
module smt_front import smt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [KEY_W-1:0] in_key_value,
  input  logic [ROW_W-1:0] in_row_index,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          q_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;
  cmd_t          in_cmd;

  // Pack the incoming word; the operation code is passed through as received.
  always_comb begin
    in_cmd.op  = in_op;
    in_cmd.key = in_key_value;
    in_cmd.row = in_row_index;
  end

  assign in_stall  = (cnt_r == CW'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

/* src/smt_back.sv */
// Back part of the sliding mode tracker: table memory, search, rescan and result.
// It depends on smt_pkg and takes commands from smt_front.
module smt_back import smt_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_mode_key,
  output logic [CNT_W-1:0] out_mode_count,
  output logic             out_mode_valid,
  output logic [DN_W-1:0]  out_distinct_nonzero,
  output logic [1:0]       out_error_code
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  entry_t           mem [ENTRIES];
  entry_t           rd_q;

  logic [1:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  logic [UW-1:0]    nz_r, nz_nxt;
  logic [CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [KEY_W-1:0] best_key_r, best_key_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [UW-1:0]    issue_r, issue_nxt;
  logic             dvld_r, dvld_nxt;
  logic [IW-1:0]    didx_r, didx_nxt;
  logic [KEY_W-1:0] pick_key_r, pick_key_nxt;
  logic [CNT_W-1:0] pick_cnt_r, pick_cnt_nxt;
  logic [ROW_W-1:0] pick_frow_r, pick_frow_nxt;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [CNT_W-1:0] new_cnt;
  logic [ROW_W-1:0] new_frow;
  logic             slot_free;
  logic             mode_ok;

  assign slot_free = !out_valid || !out_stall;
  assign mode_ok   = best_vld_r && (best_cnt_r != '0);

  // Updated count and first row for an add that hit an existing row.
  always_comb begin
    new_cnt  = (rd_q.cnt == '1) ? rd_q.cnt : rd_q.cnt + 1'b1;
    new_frow = rd_q.frow;
    if (rd_q.cnt == '0 || cmd_r.row < rd_q.frow) begin
      new_frow = cmd_r.row;
    end
  end

  // Sequencer: search, rescan and table update.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    used_nxt      = used_r;
    nz_nxt        = nz_r;
    best_cnt_nxt  = best_cnt_r;
    best_key_nxt  = best_key_r;
    best_vld_nxt  = best_vld_r;
    err_nxt       = err_r;
    issue_nxt     = issue_r;
    dvld_nxt      = 1'b0;
    didx_nxt      = didx_r;
    pick_key_nxt  = pick_key_r;
    pick_cnt_nxt  = pick_cnt_r;
    pick_frow_nxt = pick_frow_r;
    cmd_pop       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = didx_r;
    wr_data       = rd_q;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          err_nxt   = ERR_OK;
          issue_nxt = '0;
          unique case (cmd.op)
            OP_CLEAR: begin
              used_nxt     = '0;
              nz_nxt       = '0;
              best_cnt_nxt = '0;
              best_key_nxt = '0;
              best_vld_nxt = 1'b0;
              state_nxt    = ST_RESP;
            end
            OP_QUERY: begin
              state_nxt = (best_vld_r || used_r == '0) ? ST_RESP : ST_SCAN;
            end
            default: begin
              state_nxt = ST_SRCH;
            end
          endcase
        end
      end

      ST_SRCH: begin
        // Issue the next read while the previous row is compared.
        if (issue_r < used_r) begin
          rd_en     = 1'b1;
          dvld_nxt  = 1'b1;
          didx_nxt  = issue_r[IW-1:0];
          issue_nxt = issue_r + 1'b1;
        end
        if (dvld_r && rd_q.key == cmd_r.key) begin
          dvld_nxt  = 1'b0;
          state_nxt = ST_RESP;
          wr_addr   = didx_r;
          if (cmd_r.op == OP_ADD) begin
            wr_en         = 1'b1;
            wr_data.key   = rd_q.key;
            wr_data.cnt   = new_cnt;
            wr_data.frow  = new_frow;
            if (rd_q.cnt == '0) begin
              nz_nxt = nz_r + 1'b1;
            end
            if (new_cnt > best_cnt_r) begin
              best_vld_nxt = 1'b1;
              best_cnt_nxt = new_cnt;
              best_key_nxt = cmd_r.key;
            end
          end else if (rd_q.cnt == '0) begin
            err_nxt = ERR_ABSENT;
          end else begin
            wr_en        = 1'b1;
            wr_data.key  = rd_q.key;
            wr_data.cnt  = rd_q.cnt - 1'b1;
            wr_data.frow = rd_q.frow;
            if (rd_q.cnt == CNT_W'(1)) begin
              nz_nxt = nz_r - 1'b1;
            end
            if (best_cnt_r == rd_q.cnt && best_key_r == cmd_r.key) begin
              best_vld_nxt = 1'b0;
            end
          end
        end else if (!dvld_r && issue_r == used_r) begin
          // Every used row compared without a hit.
          state_nxt = ST_RESP;
          if (cmd_r.op != OP_ADD) begin
            err_nxt = ERR_ABSENT;
          end else if (used_r == UW'(ENTRIES)) begin
            err_nxt = ERR_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = used_r[IW-1:0];
            wr_data.key  = cmd_r.key;
            wr_data.cnt  = CNT_W'(1);
            wr_data.frow = cmd_r.row;
            used_nxt     = used_r + 1'b1;
            nz_nxt       = nz_r + 1'b1;
            if (best_cnt_r == '0) begin
              best_vld_nxt = 1'b1;
              best_cnt_nxt = CNT_W'(1);
              best_key_nxt = cmd_r.key;
            end
          end
        end
      end

      ST_SCAN: begin
        if (issue_r < used_r) begin
          rd_en     = 1'b1;
          dvld_nxt  = 1'b1;
          didx_nxt  = issue_r[IW-1:0];
          issue_nxt = issue_r + 1'b1;
        end
        if (dvld_r) begin
          if (didx_r == '0 || rd_q.cnt > pick_cnt_r ||
              (rd_q.cnt == pick_cnt_r && rd_q.frow < pick_frow_r)) begin
            pick_key_nxt  = rd_q.key;
            pick_cnt_nxt  = rd_q.cnt;
            pick_frow_nxt = rd_q.frow;
          end
        end else if (issue_r == used_r) begin
          best_key_nxt = pick_key_r;
          best_cnt_nxt = pick_cnt_r;
          best_vld_nxt = (pick_cnt_r != '0);
          state_nxt    = ST_RESP;
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      nz_r       <= '0;
      best_cnt_r <= '0;
      best_key_r <= '0;
      best_vld_r <= 1'b0;
      dvld_r     <= 1'b0;
      issue_r    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      nz_r       <= nz_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_key_r <= best_key_nxt;
      best_vld_r <= best_vld_nxt;
      dvld_r     <= dvld_nxt;
      issue_r    <= issue_nxt;
      if (state_r == ST_RESP && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result word carry no reset.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    err_r       <= err_nxt;
    didx_r      <= didx_nxt;
    pick_key_r  <= pick_key_nxt;
    pick_cnt_r  <= pick_cnt_nxt;
    pick_frow_r <= pick_frow_nxt;
    if (state_r == ST_RESP && slot_free) begin
      out_mode_key         <= mode_ok ? best_key_r : '0;
      out_mode_count       <= mode_ok ? best_cnt_r : '0;
      out_mode_valid       <= mode_ok;
      out_distinct_nonzero <= DN_W'(nz_r);
      out_error_code       <= err_r;
    end
  end

  // Table memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

/* dv/tb_sliding_mode_tracker.sv */
// Testbench for the sliding mode tracker: directed and random words, checked against
// a behavioural frequency table held in a small scoreboard class.
// It depends on smt_pkg and the sliding_mode_tracker RTL.
module tb_sliding_mode_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import smt_pkg::*;

  localparam int ENTRIES = 256;

  // One expected result word.
  typedef struct {
    logic [KEY_W-1:0] mkey;
    logic [CNT_W-1:0] mcnt;
    logic             mvalid;
    logic [DN_W-1:0]  distinct;
    logic [1:0]       err;
  } mode_word_t;

  // Frequency table shadow and queue of pending mode words.
  class mode_table_sb;
    logic [KEY_W-1:0] tkey [ENTRIES];
    logic [CNT_W-1:0] tcnt [ENTRIES];
    logic [ROW_W-1:0] tfrow [ENTRIES];
    bit               tused [ENTRIES];
    int               rows_used;
    int               live_keys;
    logic [CNT_W-1:0] top_cnt;
    logic [KEY_W-1:0] top_key;
    bit               top_ok;
    mode_word_t       pending[$];
    int               errors;

    function void wipe();
      for (int i = 0; i < ENTRIES; i++) begin
        tcnt[i] = '0;
        tused[i] = 0;
      end
      rows_used = 0;
      live_keys = 0;
      top_cnt = '0;
      top_key = '0;
      top_ok = 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (tused[i] && tkey[i] == k) return i;
      return ENTRIES;
    endfunction

    // Apply one accepted word and queue the mode word it should produce.
    function void note_input(logic [1:0] op, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r);
      mode_word_t w;
      int idx;
      int pick;
      logic [CNT_W-1:0] c;
      logic [1:0] err;
      err = ERR_OK;
      case (op)
        OP_ADD: begin
          idx = lookup(k);
          if (idx >= ENTRIES && rows_used >= ENTRIES) begin
            err = ERR_FULL;
          end else begin
            if (idx >= ENTRIES) begin
              idx = rows_used;
              rows_used++;
              tused[idx] = 1;
              tkey[idx] = k;
              tcnt[idx] = '0;
              tfrow[idx] = r;
            end
            c = tcnt[idx];
            if (c == 0) begin
              live_keys++;
              tfrow[idx] = r;
            end else if (r < tfrow[idx]) begin
              tfrow[idx] = r;
            end
            if (c != '1) c++;
            tcnt[idx] = c;
            if (c > top_cnt) begin
              top_ok = 1;
              top_cnt = c;
              top_key = k;
            end
          end
        end
        OP_REMOVE: begin
          idx = lookup(k);
          if (idx >= ENTRIES || tcnt[idx] == 0) begin
            err = ERR_ABSENT;
          end else begin
            if (tcnt[idx] == 1) live_keys--;
            if (top_cnt == tcnt[idx] && top_key == k) top_ok = 0;
            tcnt[idx] = tcnt[idx] - 1;
          end
        end
        OP_QUERY: begin
          if (!top_ok && rows_used != 0) begin
            pick = 0;
            for (int i = 1; i < ENTRIES; i++) begin
              if (!tused[i]) continue;
              if (tcnt[i] > tcnt[pick] ||
                  (tcnt[i] == tcnt[pick] && tfrow[i] < tfrow[pick]))
                pick = i;
            end
            top_key = tkey[pick];
            top_cnt = tcnt[pick];
            top_ok = top_cnt > 0;
          end
        end
        default: wipe();
      endcase
      w.mvalid = top_ok && top_cnt > 0;
      w.mkey = w.mvalid ? top_key : '0;
      w.mcnt = w.mvalid ? top_cnt : '0;
      w.distinct = live_keys[DN_W-1:0];
      w.err = err;
      pending.push_back(w);
    endfunction

    // Compare one result word against the oldest expectation.
    function void check_result(logic [KEY_W-1:0] k, logic [CNT_W-1:0] c, logic v,
                               logic [DN_W-1:0] d, logic [1:0] e);
      mode_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (k !== w.mkey) begin
        $error("mode_key exp %h got %h", w.mkey, k); errors++;
      end
      if (c !== w.mcnt) begin
        $error("mode_count exp %0d got %0d", w.mcnt, c); errors++;
      end
      if (v !== w.mvalid) begin
        $error("mode_valid exp %0b got %0b", w.mvalid, v); errors++;
      end
      if (d !== w.distinct) begin
        $error("distinct_nonzero exp %0d got %0d", w.distinct, d); errors++;
      end
      if (e !== w.err) begin
        $error("error_code exp %0d got %0d", w.err, e); errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_op;
  logic [KEY_W-1:0] in_key_value;
  logic [ROW_W-1:0] in_row_index;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] out_mode_key;
  logic [CNT_W-1:0] out_mode_count;
  logic             out_mode_valid;
  logic [DN_W-1:0]  out_distinct_nonzero;
  logic [1:0]       out_error_code;

  mode_table_sb sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  logic [KEY_W-1:0] key_pool [16];

  sliding_mode_tracker #(.ENTRIES(ENTRIES)) dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous overall limit.
  initial begin
    #20ms;
    $display("tb_sliding_mode_tracker: done, errors");
    $finish;
  end

  // Result side: stall pattern driven at the falling edge, words checked at the rising.
  initial begin
    out_stall = 1;
    forever begin
      @(negedge clk);
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_mode_key, out_mode_count, out_mode_valid,
                      out_distinct_nonzero, out_error_code);
  end

  // Offer one word and hold it until accepted; the next call or the caller drops valid.
  task automatic send_word(logic [1:0] op, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      in_op <= 2'($urandom);
      in_key_value <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_key_value <= k;
    in_row_index <= r;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, k, r);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (ENTRIES + 20) @(negedge clk);
  endtask

  // Mostly keys from a small pool so counts build up; some fresh ones.
  task automatic random_word();
    int sel;
    logic [1:0] op;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(99);
    if (sel < 50) op = OP_ADD;
    else if (sel < 80) op = OP_REMOVE;
    else if (sel < 98) op = OP_QUERY;
    else op = OP_CLEAR;
    k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
    send_word(op, k, $urandom);
  endtask

  initial begin
    sb = new();
    sb.wipe();
    sb.errors = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid = 0;
    in_op = OP_QUERY;
    in_key_value = '0;
    in_row_index = '0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty query, absent remove, extremes, ties, stale mode, clear.
    send_word(OP_QUERY, '0, '0);
    send_word(OP_REMOVE, '1, '0);
    send_word(OP_ADD, '1, '1);
    send_word(OP_ADD, '0, 32'd5);
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, '1, 32'd7);
    send_word(OP_REMOVE, '1, '0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_ADD, '0, '1);
    send_word(OP_REMOVE, '1, '0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_CLEAR, '1, '1);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_REMOVE, 64'h5555_5555_5555_5555, '0);

    // Fill the table, then an add of a fresh key must report full.
    for (int i = 0; i < ENTRIES; i++)
      send_word(OP_ADD, 64'hA000_0000_0000_0000 + i, $urandom);
    send_word(OP_ADD, 64'h5555_5555_5555_5555, '0);
    send_word(OP_REMOVE, 64'hA000_0000_0000_0000, '0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_ADD, 64'hA000_0000_0000_0000, '0);
    send_word(OP_CLEAR, '0, '0);

    // Random phases with differing idle and stall rates.
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 1 || ph == 4) ? 70 : (ph == 3 ? 34 : 0);
      recv_stall_pct = (ph == 2) ? 70 : (ph == 3 ? 34 : 0);
      if (ph == 4) begin
        send_idle_pct = 0;
        fork
          begin
            hold_off = 1;
            repeat (400) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 45; n++) random_word();
    end
    in_valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.pending.size() == 0 && sb.errors == 0)
      $display("tb_sliding_mode_tracker: done, clean");
    else
      $display("tb_sliding_mode_tracker: done, errors");
    $finish;
  end

endmodule

/* files.f */
src/smt_pkg.sv
src/smt_front.sv
src/smt_back.sv
src/sliding_mode_tracker.sv
dv/tb_sliding_mode_tracker.sv
